// ===== src/slef_pkg.sv =====
// Package for the separable LoG edge filter: constants, register indexes,
// controller states and the command/status structs shared by every module except slef_ram.
// No dependencies.
package slef_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int KSIZE         = 7;
  localparam int RADIUS        = (KSIZE - 1) / 2;
  localparam int NUM_TAPS      = KSIZE * KSIZE;
  localparam int RING_ROWS     = 2 * RADIUS + 2;
  localparam int SLOT_W        = $clog2(RING_ROWS);

  localparam int IMG_W_W  = 11;
  localparam int IMG_H_W  = 12;
  localparam int TAPS_W   = 64;
  localparam int TAP_W    = 16;
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 13;
  localparam int ACC_W    = 48;
  localparam int RES_W    = 32;
  localparam int FRAC_W   = 14;

  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [TAPS_W-1:0]  RST_GAUSS_TAPS   = 64'd51237968355082240;
  localparam logic [TAPS_W-1:0]  RST_DERIV_TAPS   = 64'd409856136213217280;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_GAUSS_TAPS   = 2'd2,
    REG_DERIV_TAPS   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } status_t;

endpackage

// ===== src/slef_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/slef_pos.sv =====
// Raster position tracker: frame size latch, input/output counters, line store
// write address and the decision whether a transfer releases an output.
// Depends on slef_pkg.
module slef_pos #(
  parameter int MAX_WIDTH = slef_pkg::MAX_WIDTH_DEF,
  localparam int FW = $clog2(MAX_WIDTH + 1),
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int AW = $clog2(slef_pkg::RING_ROWS * MAX_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [slef_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [slef_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                                accept,
  input  logic                                opcode,
  input  logic                                frame_start,
  output logic                                emit,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic [CW-1:0]                       emit_col,
  output logic [slef_pkg::IMG_H_W-1:0]        emit_row,
  output logic                                emit_eol,
  output logic                                emit_eof,
  output logic [FW-1:0]                       frame_w,
  output logic [slef_pkg::IMG_H_W-1:0]        frame_h
);

  localparam int DW = $clog2(3 * MAX_WIDTH + 5);
  localparam int HW = slef_pkg::IMG_H_W;
  localparam int RW = slef_pkg::ROW_W;
  localparam int RST_W = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;

  logic [slef_pkg::IMG_W_W-1:0] image_width_r;
  logic [HW-1:0]                image_height_r;
  logic [FW-1:0]                frame_w_r, frame_w_nxt;
  logic [HW-1:0]                frame_h_r, frame_h_nxt;
  logic [DW-1:0]                dl_r, dl_nxt;
  logic [CW-1:0]                in_col_r, in_col_nxt;
  logic [RW-1:0]                in_row_r, in_row_nxt;
  logic [CW-1:0]                out_col_r, out_col_nxt;
  logic [HW-1:0]                out_row_r, out_row_nxt;
  logic [DW-1:0]                diff_r, diff_nxt;

  logic [FW-1:0] w_lat;
  logic [HW-1:0] h_lat;
  logic [FW-1:0] w_b;
  logic [HW-1:0] h_b;
  logic [DW-1:0] dl_b, diff_b, diff_a;
  logic [CW-1:0] col_b, ocol_b;
  logic [RW-1:0] row_b;
  logic [HW-1:0] orow_b;
  logic [CW:0]   col_inc, ocol_inc;
  logic          fs_eff, wr, flush_ok, adv, eol;

  always_comb begin
    if (image_width_r < 11'd4) begin
      w_lat = FW'(4);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_lat = FW'(MAX_WIDTH);
    end else begin
      w_lat = FW'(image_width_r);
    end
    h_lat = (image_height_r < 12'd4) ? 12'd4 : image_height_r;
  end

  always_comb begin
    fs_eff = !opcode && frame_start;
    w_b    = frame_w_r;
    h_b    = frame_h_r;
    dl_b   = dl_r;
    col_b  = in_col_r;
    row_b  = in_row_r;
    ocol_b = out_col_r;
    orow_b = out_row_r;
    diff_b = diff_r;
    if (fs_eff) begin
      w_b    = w_lat;
      h_b    = h_lat;
      dl_b   = DW'(3 * 32'(w_lat) + 3);
      col_b  = '0;
      row_b  = '0;
      ocol_b = '0;
      orow_b = '0;
      diff_b = '0;
    end

    // Pixels are stored while the frame still expects them; past the last
    // line, any transfer advances the input position until the drain ends.
    wr       = !opcode && (row_b < RW'(h_b));
    flush_ok = (row_b >= RW'(h_b)) &&
               ((row_b < RW'(h_b) + RW'(3)) ||
                ((row_b == RW'(h_b) + RW'(3)) && (col_b < CW'(3))));
    adv      = wr || flush_ok;

    col_inc     = {1'b0, col_b} + 1'b1;
    in_col_nxt  = col_b;
    in_row_nxt  = row_b;
    diff_a      = diff_b;
    if (adv) begin
      diff_a = diff_b + 1'b1;
      if (col_inc >= (CW+1)'(w_b)) begin
        in_col_nxt = '0;
        in_row_nxt = row_b + 1'b1;
      end else begin
        in_col_nxt = col_inc[CW-1:0];
      end
    end

    emit = (orow_b < h_b) && (diff_a > dl_b);
    eol  = ({1'b0, ocol_b} == (CW+1)'(w_b) - 1'b1);

    ocol_inc    = {1'b0, ocol_b} + 1'b1;
    out_col_nxt = ocol_b;
    out_row_nxt = orow_b;
    diff_nxt    = diff_a;
    if (emit) begin
      diff_nxt = diff_a - 1'b1;
      if (eol) begin
        out_col_nxt = '0;
        out_row_nxt = orow_b + 1'b1;
      end else begin
        out_col_nxt = ocol_inc[CW-1:0];
      end
    end

    frame_w_nxt = w_b;
    frame_h_nxt = h_b;
    dl_nxt      = dl_b;
  end

  assign emit_col = ocol_b;
  assign emit_row = orow_b;
  assign emit_eol = eol;
  assign emit_eof = eol && (orow_b == h_b - 1'b1);
  assign wr_en    = accept && wr;
  assign wr_addr  = AW'(row_b[slef_pkg::SLOT_W-1:0]) * AW'(MAX_WIDTH) + AW'(col_b);
  assign frame_w  = frame_w_r;
  assign frame_h  = frame_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= slef_pkg::RST_IMAGE_WIDTH;
      image_height_r <= slef_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_wr_en) begin
      if (cfg_addr == slef_pkg::REG_IMAGE_WIDTH) begin
        image_width_r <= cfg_wr_data[slef_pkg::IMG_W_W-1:0];
      end
      if (cfg_addr == slef_pkg::REG_IMAGE_HEIGHT) begin
        image_height_r <= cfg_wr_data[HW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FW'(RST_W);
      frame_h_r <= slef_pkg::RST_IMAGE_HEIGHT;
      dl_r      <= DW'(3 * RST_W + 3);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      diff_r    <= '0;
    end else if (accept) begin
      frame_w_r <= frame_w_nxt;
      frame_h_r <= frame_h_nxt;
      dl_r      <= dl_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      diff_r    <= diff_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The input position never runs more than one window delay ahead.
  a_diff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    diff_r <= dl_r) else $error("input/output distance exceeds window delay");
`endif

endmodule

// ===== src/slef_ctrl.sv =====
// Controller state machine: accepts a transfer, runs the 49-tap pass of the
// datapath and hands the result to the output register. Depends on slef_pkg.
module slef_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              emit,
  input  slef_pkg::status_t status,
  output slef_pkg::cmd_t    cmd
);

  slef_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slef_pkg::ST_IDLE: begin
        if (in_tvalid && emit) begin
          state_nxt = slef_pkg::ST_RUN;
        end
      end
      slef_pkg::ST_RUN: begin
        if (status.last_issue) begin
          state_nxt = slef_pkg::ST_DRAIN;
        end
      end
      slef_pkg::ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = slef_pkg::ST_DONE;
        end
      end
      slef_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_nxt = slef_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slef_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.start   = 1'b0;
    cmd.issue   = 1'b0;
    cmd.publish = 1'b0;
    case (state_r)
      slef_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid && emit;
      end
      slef_pkg::ST_RUN:   cmd.issue = 1'b1;
      slef_pkg::ST_DRAIN: ;
      slef_pkg::ST_DONE:  cmd.publish = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slef_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/slef_dp.sv =====
// Datapath: tap registers, window address generation with mirrored borders,
// the multiply-accumulate pipeline, rounding and the output register.
// Depends on slef_pkg.
module slef_dp #(
  parameter int MAX_WIDTH = slef_pkg::MAX_WIDTH_DEF,
  localparam int FW = $clog2(MAX_WIDTH + 1),
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int AW = $clog2(slef_pkg::RING_ROWS * MAX_WIDTH)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [slef_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [slef_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  slef_pkg::cmd_t                     cmd,
  output slef_pkg::status_t                  status,
  input  logic [CW-1:0]                      emit_col,
  input  logic [slef_pkg::IMG_H_W-1:0]       emit_row,
  input  logic                               emit_eol,
  input  logic                               emit_eof,
  input  logic [FW-1:0]                      frame_w,
  input  logic [slef_pkg::IMG_H_W-1:0]       frame_h,
  output logic [AW-1:0]                      rd_addr,
  input  logic [slef_pkg::PIX_W-1:0]         rd_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [slef_pkg::RES_W-1:0]         out_value,
  output logic                               out_edge,
  output logic                               out_eol,
  output logic                               out_eof
);

  localparam int XW = CW + 3;
  localparam int YW = slef_pkg::ROW_W + 1;
  localparam int TW = slef_pkg::TAP_W;
  localparam int PW = 2 * TW + 1;
  localparam int KW = PW + 1;
  localparam int MW = KW + slef_pkg::PIX_W + 1;
  localparam int ACW = slef_pkg::ACC_W;
  localparam logic signed [ACW-1:0] SAT_HI = 48'sd2147483647;
  localparam logic signed [ACW-1:0] SAT_LO = -48'sd2147483648;
  localparam logic signed [ACW-1:0] HALF   = 48'sd8192;

  logic [slef_pkg::TAPS_W-1:0] gauss_r, deriv_r;
  logic [CW-1:0]               col_r;
  logic [slef_pkg::IMG_H_W-1:0] row_r;
  logic                        eol_r, eof_r;
  logic [2:0]                  iy_r, ix_r;

  logic signed [PW-1:0]  p1_r, p2_r;
  logic signed [KW-1:0]  k_r;
  logic [slef_pkg::PIX_W-1:0] pix_r;
  logic signed [MW-1:0]  m_r;
  logic signed [ACW-1:0] acc_r;
  logic                  v1_r, v2_r, v3_r;

  logic                  out_valid_r;
  logic [slef_pkg::RES_W-1:0] out_value_r;
  logic                  out_edge_r, out_eol_r, out_eof_r;

  logic signed [YW-1:0] rr, ys;
  logic signed [XW-1:0] cc, xs;
  logic [2:0]           ay3, ax3;
  logic [1:0]           ay, ax;
  logic [TW-1:0]        g_y, g_x, h_y, h_x;
  logic signed [PW-1:0] p1, p2;
  logic signed [ACW-1:0] rnd, q;
  logic [slef_pkg::RES_W-1:0] q_sat;
  logic                 pipe_empty;

  // Window coordinates with mirror-101 borders; one reflection is enough
  // because the frame is always at least four pixels on each side.
  always_comb begin
    rr = $signed(YW'(row_r)) + $signed(YW'(iy_r)) - $signed(YW'(slef_pkg::RADIUS));
    if (rr < 0) begin
      ys = -rr;
    end else if (rr >= $signed(YW'(frame_h))) begin
      ys = $signed(YW'(frame_h)) + $signed(YW'(frame_h)) - $signed(YW'(2)) - rr;
    end else begin
      ys = rr;
    end
    cc = $signed(XW'(col_r)) + $signed(XW'(ix_r)) - $signed(XW'(slef_pkg::RADIUS));
    if (cc < 0) begin
      xs = -cc;
    end else if (cc >= $signed(XW'(frame_w))) begin
      xs = $signed(XW'(frame_w)) + $signed(XW'(frame_w)) - $signed(XW'(2)) - cc;
    end else begin
      xs = cc;
    end
    ay3 = (iy_r < 3'd3) ? 3'd3 - iy_r : iy_r - 3'd3;
    ax3 = (ix_r < 3'd3) ? 3'd3 - ix_r : ix_r - 3'd3;
    ay  = ay3[1:0];
    ax  = ax3[1:0];
    g_y = gauss_r[TW*ay +: TW];
    g_x = gauss_r[TW*ax +: TW];
    h_y = deriv_r[TW*ay +: TW];
    h_x = deriv_r[TW*ax +: TW];
    p1  = $signed({1'b0, g_y}) * $signed({h_x[TW-1], h_x});
    p2  = $signed({h_y[TW-1], h_y}) * $signed({1'b0, g_x});
  end

  assign rd_addr = AW'(ys[slef_pkg::SLOT_W-1:0]) * AW'(MAX_WIDTH)
                 + AW'(xs[CW-1:0]);

  // Round half up at 14 fractional bits, which is a floor after the offset.
  always_comb begin
    rnd = acc_r + HALF;
    q   = rnd >>> slef_pkg::FRAC_W;
    if (q > SAT_HI) begin
      q_sat = SAT_HI[slef_pkg::RES_W-1:0];
    end else if (q < SAT_LO) begin
      q_sat = SAT_LO[slef_pkg::RES_W-1:0];
    end else begin
      q_sat = q[slef_pkg::RES_W-1:0];
    end
  end

  assign pipe_empty        = !v1_r && !v2_r && !v3_r;
  assign status.last_issue = (iy_r == 3'(slef_pkg::KSIZE - 1))
                          && (ix_r == 3'(slef_pkg::KSIZE - 1));
  assign status.pipe_empty = pipe_empty;
  assign status.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gauss_r <= slef_pkg::RST_GAUSS_TAPS;
      deriv_r <= slef_pkg::RST_DERIV_TAPS;
    end else if (cfg_wr_en) begin
      if (cfg_addr == slef_pkg::REG_GAUSS_TAPS) begin
        gauss_r <= cfg_wr_data;
      end
      if (cfg_addr == slef_pkg::REG_DERIV_TAPS) begin
        deriv_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iy_r <= '0;
      ix_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.start) begin
        iy_r <= '0;
        ix_r <= '0;
      end else if (cmd.issue) begin
        if (ix_r == 3'(slef_pkg::KSIZE - 1)) begin
          ix_r <= '0;
          iy_r <= iy_r + 1'b1;
        end else begin
          ix_r <= ix_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col_r <= emit_col;
      row_r <= emit_row;
      eol_r <= emit_eol;
      eof_r <= emit_eof;
    end
    p1_r  <= p1;
    p2_r  <= p2;
    k_r   <= KW'(p1_r) + KW'(p2_r);
    pix_r <= rd_data;
    m_r   <= MW'(k_r) * $signed({1'b0, pix_r});
    if (cmd.start) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_r + ACW'(m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_value_r <= q_sat;
      out_edge_r  <= !q_sat[slef_pkg::RES_W-1] && (q_sat != '0);
      out_eol_r   <= eol_r;
      out_eof_r   <= eof_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_value_r;
  assign out_edge   = out_edge_r;
  assign out_eol    = out_eol_r;
  assign out_eof    = out_eof_r;

`ifndef NO_ASSERTIONS
  a_publish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> pipe_empty) else $error("result published with taps in flight");
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (acc_r == '0)) else $error("accumulator not cleared at start");
`endif

endmodule

// ===== src/separable_log_edge_filter.sv =====
// Top level of the separable 7x7 Laplacian-of-Gaussian edge filter.
// Depends on slef_pkg, slef_ram, slef_pos, slef_ctrl and slef_dp.
//
// This block filters 8-bit grayscale pixels in raster order with a 7x7
// Laplacian-of-Gaussian kernel g(y)h(x)+h(y)g(x), mirrored borders without
// edge repetition, and returns a signed result with 14 fractional bits,
// rounded half up and saturated to 32 bits, plus an edge flag (result above
// zero) and end-of-line / end-of-frame marks. Outputs trail the inputs by
// three lines and three pixels; after the last pixel, send flush transfers
// (opcode 1) to drain the remaining outputs. A transfer that releases no
// output leaves the input open; one that releases an output keeps the
// input closed while the 49 window taps are issued, the pipeline drains
// and the result is handed over, so the block takes no new transfer until
// that output is done, because the 49 window taps are read one per
// cycle from the single read port of the line store and pass through a
// four-stage multiply-accumulate pipeline. The hand-over stretches
// while the previous result still waits in the output register. The
// finished result sits in that register, so the next transfer is taken
// while it waits. Width and height take effect at the next frame_start;
// taps are read as each output is computed. Write configuration only while
// the block is idle.
module separable_log_edge_filter #(
  parameter int MAX_WIDTH = slef_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] pixel
  input  logic [1:0]                      in_tuser,   // [0] opcode, [1] frame_start
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [39:0]                     out_tdata,  // [31:0] log_value,
                                                      // [32] edge_res, [33] end_of_line
  output logic                            out_tlast,  // end_of_frame
  input  logic                            cfg_wr_en,
  input  logic [slef_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [slef_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int FW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(slef_pkg::RING_ROWS * MAX_WIDTH);

  logic                          accept, emit, wr_en;
  logic [AW-1:0]                 wr_addr, rd_addr;
  logic [slef_pkg::PIX_W-1:0]    rd_data;
  logic [CW-1:0]                 emit_col;
  logic [slef_pkg::IMG_H_W-1:0]  emit_row, frame_h;
  logic                          emit_eol, emit_eof;
  logic [FW-1:0]                 frame_w;
  slef_pkg::cmd_t                cmd;
  slef_pkg::status_t             status;
  logic [slef_pkg::RES_W-1:0]    out_value;
  logic                          out_edge, out_eol, out_eof;

  // A transfer on the input side happens when both valid and ready are high.
  assign accept = in_tvalid && in_tready;

  slef_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .opcode      (in_tuser[0]),
    .frame_start (in_tuser[1]),
    .emit        (emit),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .emit_col    (emit_col),
    .emit_row    (emit_row),
    .emit_eol    (emit_eol),
    .emit_eof    (emit_eof),
    .frame_w     (frame_w),
    .frame_h     (frame_h)
  );

  // Eight line slots of MAX_WIDTH pixels; the row number picks the slot.
  slef_ram #(
    .WIDTH (slef_pkg::PIX_W),
    .DEPTH (slef_pkg::RING_ROWS * MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  slef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .emit      (emit),
    .status    (status),
    .cmd       (cmd)
  );

  slef_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .emit_col    (emit_col),
    .emit_row    (emit_row),
    .emit_eol    (emit_eol),
    .emit_eof    (emit_eof),
    .frame_w     (frame_w),
    .frame_h     (frame_h),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_value   (out_value),
    .out_edge    (out_edge),
    .out_eol     (out_eol),
    .out_eof     (out_eof)
  );

  assign out_tdata = {6'b0, out_eol, out_edge, out_value};
  assign out_tlast = out_eof;

endmodule

// ===== dv/separable_log_edge_filter_tb.sv =====
// Self-checking testbench for the separable 7x7 LoG edge filter.
// Depends on slef_pkg and separable_log_edge_filter; a built-in predictor
// computes every expected filter output and checks it against the result bus.
`timescale 1ns / 1ps

module separable_log_edge_filter_tb;

  localparam int CLK_PERIOD = 12;
  localparam int STORE_MAX_W = 1024;
  localparam int STORE_ROWS = 8;
  localparam int TARGET_ITEMS = 1850;
  localparam bit OP_PIXEL = 1'b0;
  localparam bit OP_FLUSH = 1'b1;

  typedef struct {
    bit       op;
    bit [7:0] px;
    bit       fs;
  } pix_item_t;

  typedef struct {
    logic signed [31:0] log_value;
    bit                 edge_res;
    bit                 eol;
    bit                 eof;
  } filt_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] pixel
  logic [1:0]  in_tuser = '0;   // [0] opcode, [1] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] log_value, [32] edge_res, [33] end_of_line
  logic        out_tlast;       // end_of_frame
  logic        cfg_wr_en = 1'b0;
  logic [slef_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [slef_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

  separable_log_edge_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Pixels and flush steps waiting to be driven, and filter outputs that the
  // predictor has released but the block has not yet delivered.
  pix_item_t pending_pix[$];
  filt_res_t expected_px[$];
  int errors = 0;
  int in_transfers = 0;   // bumped by the monitor on every input transfer
  int driven_count = 0;   // input transfers the driver has retired
  int out_transfers = 0;  // bumped by the monitor on every output transfer
  int out_seen = 0;       // output transfers the result side has retired

  // Shadow copy of the block's registers and raster state.
  logic [10:0] reg_width;
  logic [11:0] reg_height;
  logic [63:0] reg_gauss;
  logic [63:0] reg_deriv;
  int unsigned frame_w, frame_h;
  int unsigned in_col, in_row, out_col, out_row;
  bit [7:0] line_mem [0:STORE_ROWS*STORE_MAX_W-1];

  function automatic int mirror101(int i, int n);
    if (i < 0) return -i;
    if (i >= n) return 2 * n - 2 - i;
    return i;
  endfunction

  function automatic longint gauss_at(int i);
    return longint'({48'd0, reg_gauss[16*i +: 16]});
  endfunction

  function automatic longint deriv_at(int i);
    logic signed [15:0] t;
    t = reg_deriv[16*i +: 16];
    return longint'(t);
  endfunction

  // Full 7x7 sum in Q.28, then round half up to Q.14 and clamp to 32 bits.
  // An arithmetic shift gives the floor for both signs, which is what the
  // rounding needs once the half is added.
  function automatic logic signed [31:0] log_response(int r, int c);
    longint acc;
    longint k;
    int yy, xx;
    acc = 0;
    for (int dy = -3; dy <= 3; dy++) begin
      yy = mirror101(r + dy, frame_h);
      for (int dx = -3; dx <= 3; dx++) begin
        xx = mirror101(c + dx, frame_w);
        k = gauss_at(dy < 0 ? -dy : dy) * deriv_at(dx < 0 ? -dx : dx)
          + deriv_at(dy < 0 ? -dy : dy) * gauss_at(dx < 0 ? -dx : dx);
        acc += k * longint'(line_mem[(yy % STORE_ROWS) * STORE_MAX_W + xx]);
      end
    end
    acc = (acc + 8192) >>> 14;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  function automatic void latch_frame_size();
    frame_w = reg_width < 4 ? 4 : (reg_width > STORE_MAX_W ? STORE_MAX_W : reg_width);
    frame_h = reg_height < 4 ? 4 : reg_height;
  endfunction

  function automatic void step_raster_in();
    in_col++;
    if (in_col >= frame_w) begin
      in_col = 0;
      in_row++;
    end
  endfunction

  // Advance the shadow state by one accepted transfer and queue the output
  // it releases, if any.
  function automatic void filter_step(bit op, bit [7:0] px, bit fs);
    longint unsigned total, lag, in_lin, out_lin;
    filt_res_t r;
    if (op == OP_PIXEL && fs) begin
      latch_frame_size();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    total = longint'(frame_w) * frame_h;
    lag = 3 * longint'(frame_w) + 3;
    in_lin = longint'(in_row) * frame_w + in_col;
    if (op == OP_PIXEL && in_row < frame_h) begin
      line_mem[(in_row % STORE_ROWS) * STORE_MAX_W + in_col] = px;
      step_raster_in();
    end else if (in_row >= frame_h && in_lin < total + lag) begin
      step_raster_in();
    end
    in_lin = longint'(in_row) * frame_w + in_col;
    out_lin = longint'(out_row) * frame_w + out_col;
    if (out_row >= frame_h || in_lin < out_lin + lag + 1) return;
    r.log_value = log_response(out_row, out_col);
    r.edge_res = r.log_value > 0;
    r.eol = out_col == frame_w - 1;
    r.eof = out_lin == total - 1;
    expected_px.push_back(r);
    out_col++;
    if (out_col >= frame_w) begin
      out_col = 0;
      out_row++;
    end
  endfunction

  // Monitor: every transfer on either side is seen at the rising edge.
  always @(posedge clk) begin
    filt_res_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        filter_step(in_tuser[0], in_tdata, in_tuser[1]);
        in_transfers++;
      end
      if (out_tvalid && out_tready) begin
        out_transfers++;
        if (expected_px.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected output transfer %h last=%b", out_tdata, out_tlast);
        end else begin
          e = expected_px.pop_front();
          if (out_tdata[31:0] !== e.log_value || out_tdata[32] !== e.edge_res ||
              out_tdata[33] !== e.eol || out_tlast !== e.eof) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: expected value=%0d edge=%b eol=%b eof=%b, got %0d %b %b %b",
                       e.log_value, e.edge_res, e.eol, e.eof, $signed(out_tdata[31:0]),
                       out_tdata[32], out_tdata[33], out_tlast);
          end
        end
      end
    end
  end

  // Input driver: holds each item until its transfer, then idles for a drawn
  // number of cycles. A fast mode with no idling flips on and off at random.
  int in_gap = 0;
  bit in_fast = 1'b0;
  always @(negedge clk) begin
    pix_item_t it;
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (rst_n) begin
      if (in_tvalid && in_transfers != driven_count) begin
        driven_count = in_transfers;
        nxt_valid = 1'b0;
        if ($urandom_range(0, 63) == 0) in_fast = ~in_fast;
        in_gap = in_fast ? 0 : $urandom_range(0, 15);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_pix.size() > 0) begin
          it = pending_pix.pop_front();
          in_tdata <= it.px;
          in_tuser <= {it.fs, it.op};
          nxt_valid = 1'b1;
        end
      end
    end
    in_tvalid <= nxt_valid;
  end

  // Result side: back-pressure drawn after every output transfer that the
  // monitor has counted.
  int out_stall = 0;
  bit out_fast = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_transfers != out_seen) begin
        out_seen = out_transfers;
        if ($urandom_range(0, 63) == 0) out_fast = ~out_fast;
        out_stall = out_fast ? 0 : $urandom_range(0, 15);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_tready <= out_stall == 0;
    end
  end

  task automatic write_reg(slef_pkg::reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= val;
    case (idx)
      slef_pkg::REG_IMAGE_WIDTH: reg_width = val[10:0];
      slef_pkg::REG_IMAGE_HEIGHT: reg_height = val[11:0];
      slef_pkg::REG_GAUSS_TAPS: reg_gauss = val;
      default: reg_deriv = val;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every queued item has gone in and every output has come out,
  // then lets the block finish any window computation still in flight.
  task automatic wait_idle();
    while (pending_pix.size() > 0 || in_tvalid || expected_px.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic bit [7:0] draw_pixel(int style);
    case (style)
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: return 8'hFF;
      default: return $urandom_range(0, 7) == 0 ? 8'h00 : 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_item(bit op, bit [7:0] px, bit fs);
    pix_item_t it;
    it.op = op; it.px = px; it.fs = fs;
    pending_pix.push_back(it);
  endfunction

  // One frame of w x h pixels (w, h already clamped) plus its drain. With
  // noise on, stray flushes land mid frame, frame_start rides on flushes and
  // surplus pixels stand in for drain steps. A nonzero cut_at stops the frame
  // early so that the next frame_start restarts it.
  function automatic void push_frame(int w, int h, int style, bit noise, int cut_at);
    push_item(OP_PIXEL, draw_pixel(style), 1'b1);
    for (int i = 1; i < w * h; i++) begin
      if (cut_at != 0 && i == cut_at) return;
      if (noise && $urandom_range(0, 30) == 0)
        push_item(OP_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      push_item(OP_PIXEL, draw_pixel(style), 1'b0);
    end
    for (int d = 0; d < 3 * w + 3 + (noise ? $urandom_range(0, 4) : 0); d++) begin
      if (noise && $urandom_range(0, 5) == 0)
        push_item(OP_PIXEL, 8'($urandom_range(0, 255)), 1'b0);
      else
        push_item(OP_FLUSH, 8'($urandom_range(0, 255)),
                  noise ? 1'($urandom_range(0, 1)) : 1'b0);
    end
  endfunction

  function automatic logic [63:0] draw_taps();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom} & 64'h0FFF_0FFF_0FFF_0FFF;
      1: return {16'h0040, 16'h0400, 16'h1000, 16'h4000};
      2: return {4{16'h8000}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int w, h;
    reg_width = slef_pkg::RST_IMAGE_WIDTH;
    reg_height = slef_pkg::RST_IMAGE_HEIGHT;
    reg_gauss = slef_pkg::RST_GAUSS_TAPS;
    reg_deriv = slef_pkg::RST_DERIV_TAPS;
    frame_w = 640; frame_h = 480;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: smallest frame after clamping zero sizes, all-white pixels
    // with the largest taps (positive saturation), then negative saturation.
    write_reg(slef_pkg::REG_IMAGE_WIDTH, 64'd0);
    write_reg(slef_pkg::REG_IMAGE_HEIGHT, 64'd0);
    write_reg(slef_pkg::REG_GAUSS_TAPS, {64{1'b1}});
    write_reg(slef_pkg::REG_DERIV_TAPS, {4{16'h7FFF}});
    push_frame(4, 4, 2, 1'b0, 0);
    wait_idle();
    write_reg(slef_pkg::REG_DERIV_TAPS, {4{16'h8000}});
    push_frame(4, 4, 2, 1'b0, 0);
    wait_idle();

    // Widest frame from an oversized width register, cut short after a few
    // pixels; no output is due, so only the restart is exercised.
    write_reg(slef_pkg::REG_IMAGE_WIDTH, 64'd2047);
    write_reg(slef_pkg::REG_IMAGE_HEIGHT, 64'd4095);
    push_frame(1024, 4095, 0, 1'b1, 40);
    wait_idle();
    write_reg(slef_pkg::REG_IMAGE_WIDTH, 64'd1024);
    push_frame(1024, 4095, 1, 1'b0, 30);
    wait_idle();

    // Default taps at reset values, then random phases.
    write_reg(slef_pkg::REG_GAUSS_TAPS, slef_pkg::RST_GAUSS_TAPS);
    write_reg(slef_pkg::REG_DERIV_TAPS, slef_pkg::RST_DERIV_TAPS);
    while (in_transfers < TARGET_ITEMS) begin
      w = $urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 12);
      h = $urandom_range(0, 7) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 8);
      write_reg(slef_pkg::REG_IMAGE_WIDTH, 64'(w));
      write_reg(slef_pkg::REG_IMAGE_HEIGHT, 64'(h));
      if ($urandom_range(0, 1)) write_reg(slef_pkg::REG_GAUSS_TAPS, draw_taps());
      if ($urandom_range(0, 1)) write_reg(slef_pkg::REG_DERIV_TAPS, draw_taps());
      if ($urandom_range(0, 1) == 0)
        write_reg(slef_pkg::reg_idx_t'($urandom_range(0, 3)), {$urandom, $urandom} & 64'h3);
      w = reg_width < 4 ? 4 : reg_width;
      h = reg_height < 4 ? 4 : reg_height;
      for (int f = 0; f < $urandom_range(1, 3); f++) begin
        if ($urandom_range(0, 5) == 0)
          push_frame(w, h, $urandom_range(0, 3), 1'b1, $urandom_range(1, w * h - 1));
        else
          push_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 2) == 0, 0);
      end
      wait_idle();
    end

    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #36_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
